// ===== design/cid_pkg.sv =====
`timescale 1ns / 1ps

package cid_pkg;

    localparam int unsigned NumSources = 5;
    localparam logic [15:0] VectorBase = 16'h0040;

    typedef enum logic [2:0] {
        MODE_CHECK = 3'd0,
        MODE_EI    = 3'd1,
        MODE_DI    = 3'd2,
        MODE_HALT  = 3'd3,
        MODE_OTHER = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        IME_DISABLED     = 2'd0,
        IME_DISABLE_NEXT = 2'd1,
        IME_ENABLE_NEXT  = 2'd2,
        IME_ENABLED      = 2'd3
    } t_ime;

    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  enable_mask;
        logic [7:0]  flag_bits;
        logic [15:0] prog_counter;
        logic [15:0] stack_ptr;
    } t_cid_in;

    typedef struct packed {
        logic        dispatched;
        logic [15:0] next_pc;
        logic [15:0] next_sp;
        logic [15:0] push_hi_addr;
        logic [7:0]  push_hi_data;
        logic [15:0] push_lo_addr;
        logic [7:0]  push_lo_data;
        logic [7:0]  next_flags;
        logic        is_halted;
        logic        woke;
        logic [1:0]  ime_state;
    } t_cid_out;

    typedef struct packed {
        t_ime       ime;
        logic       halted;
        logic [7:0] flags_at_halt;
    } t_cid_state;

endpackage

// ===== design/cid_chan_if.sv =====
`timescale 1ns / 1ps

interface cid_chan_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== design/cid_eval.sv =====
`timescale 1ns / 1ps

module cid_eval (
    input  cid_pkg::t_cid_in    i_item,
    input  cid_pkg::t_cid_state i_state,
    output cid_pkg::t_cid_state o_state,
    output cid_pkg::t_cid_out   o_result
);

    logic [cid_pkg::NumSources-1:0] cand;
    logic [2:0]                     idx;
    logic                           found;
    cid_pkg::t_ime                  stepped;

    // lowest set source wins
    always_comb begin
        cand  = i_item.enable_mask[cid_pkg::NumSources-1:0]
              & i_item.flag_bits[cid_pkg::NumSources-1:0];
        idx   = 3'd0;
        found = 1'b0;
        for (int i = cid_pkg::NumSources - 1; i >= 0; i--) begin
            if (cand[i]) begin
                idx   = 3'(i);
                found = 1'b1;
            end
        end
    end

    always_comb begin
        case (i_state.ime)
            cid_pkg::IME_DISABLE_NEXT: stepped = cid_pkg::IME_DISABLED;
            cid_pkg::IME_ENABLE_NEXT:  stepped = cid_pkg::IME_ENABLED;
            default:                   stepped = i_state.ime;
        endcase
    end

    always_comb begin
        o_state               = i_state;
        o_result.dispatched   = 1'b0;
        o_result.next_pc      = i_item.prog_counter;
        o_result.next_sp      = i_item.stack_ptr;
        o_result.push_hi_addr = 16'h0000;
        o_result.push_hi_data = 8'h00;
        o_result.push_lo_addr = 16'h0000;
        o_result.push_lo_data = 8'h00;
        o_result.next_flags   = i_item.flag_bits;
        o_result.woke         = 1'b0;

        case (cid_pkg::t_mode'(i_item.mode))
            cid_pkg::MODE_CHECK: begin
                if (i_state.halted && (i_state.flags_at_halt != i_item.flag_bits)) begin
                    o_state.halted = 1'b0;
                    o_result.woke  = 1'b1;
                end
                if (found && ((i_state.ime == cid_pkg::IME_ENABLED) ||
                              (i_state.ime == cid_pkg::IME_DISABLE_NEXT))) begin
                    o_state.ime                 = cid_pkg::IME_DISABLED;
                    o_result.dispatched         = 1'b1;
                    o_result.next_flags[idx]    = 1'b0;
                    o_result.push_hi_addr       = i_item.stack_ptr - 16'd1;
                    o_result.push_hi_data       = i_item.prog_counter[15:8];
                    o_result.push_lo_addr       = i_item.stack_ptr;
                    o_result.push_lo_data       = i_item.prog_counter[7:0];
                    o_result.next_sp            = i_item.stack_ptr - 16'd2;
                    o_result.next_pc            = cid_pkg::VectorBase | {10'd0, idx, 3'd0};
                end
            end
            cid_pkg::MODE_EI: o_state.ime = cid_pkg::IME_ENABLE_NEXT;
            cid_pkg::MODE_DI: o_state.ime = cid_pkg::IME_DISABLE_NEXT;
            cid_pkg::MODE_HALT: begin
                o_state.halted        = 1'b1;
                o_state.flags_at_halt = i_item.flag_bits;
                o_state.ime           = stepped;
            end
            cid_pkg::MODE_OTHER: o_state.ime = stepped;
            default: ;
        endcase

        o_result.is_halted = o_state.halted;
        o_result.ime_state = o_state.ime;
    end

endmodule

// ===== design/cpu_interrupt_dispatch.sv =====
`timescale 1ns / 1ps

// channel  | dir | handshake     | word
// i_req    | in  | valid / ready | mode, enable_mask, flag_bits, prog_counter, stack_ptr
// o_rsp    | out | valid / ready | dispatched, next_pc, next_sp, push addr/data, flags, halt, ime
//
// one word in, one word out, through the input register and then the result register
// a new word is taken every cycle while the result side keeps up
// the interrupt state (master enable, halt flag, flags at halt) advances when a
// word moves from the input register into the result register, so order is kept
// a stalled result holds the result register; the input register fills behind it
// synchronous active-low reset clears master enable, halt state and both valids

module cpu_interrupt_dispatch (
    input  logic           i_clk,
    input  logic           i_rst_n,
    cid_chan_if.sink       i_req,
    cid_chan_if.source     o_rsp
);

    // input stage
    logic              r_in_valid;
    cid_pkg::t_cid_in  r_in_data;

    // result stage
    logic              r_out_valid;
    cid_pkg::t_cid_out r_out_data;

    // interrupt state
    cid_pkg::t_cid_state r_state;
    cid_pkg::t_cid_state n_state;
    cid_pkg::t_cid_out   n_result;

    logic advance;

    // the word in the input register moves on when the result slot is free
    assign advance     = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || advance;

    cid_eval u_eval (
        .i_item   (r_in_data),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in_data <= i_req.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= n_result;
        end
    end

    // state only moves with a word, never on a stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.ime           <= cid_pkg::IME_DISABLED;
            r_state.halted        <= 1'b0;
            r_state.flags_at_halt <= 8'h00;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out_data;

endmodule
